FILE: hdl/bitmap_fill_and_color_transform_defines.svh
// assertion helpers for the top-level rtl, clocked on clk and disabled in reset
`ifndef BITMAP_FILL_AND_COLOR_TRANSFORM_DEFINES_SVH
`define BITMAP_FILL_AND_COLOR_TRANSFORM_DEFINES_SVH

// same-cycle implication
`define BFCT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfct assertion failed");

// next-cycle implication
`define BFCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfct assertion failed");

`endif

FILE: hdl/bfct_pkg.sv
package bfct_pkg;

  // default geometry
  localparam int IMAGE_WIDTH_DEF  = 64;
  localparam int IMAGE_HEIGHT_DEF = 64;
  localparam int HAS_ALPHA_DEF    = 1;

  // coordinate compare width, covers the largest legal image dimension
  localparam int COORD_CMP_W = 13;

  // apb address width and register indexes
  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_MULT_RED     = 3'd0;
  localparam logic [2:0] REG_MULT_GREEN   = 3'd1;
  localparam logic [2:0] REG_MULT_BLUE    = 3'd2;
  localparam logic [2:0] REG_MULT_ALPHA   = 3'd3;
  localparam logic [2:0] REG_OFFSET_RED   = 3'd4;
  localparam logic [2:0] REG_OFFSET_GREEN = 3'd5;
  localparam logic [2:0] REG_OFFSET_BLUE  = 3'd6;
  localparam logic [2:0] REG_OFFSET_ALPHA = 3'd7;

  // command modes
  localparam logic [1:0] MODE_FILL  = 2'd0;
  localparam logic [1:0] MODE_XFORM = 2'd1;
  localparam logic [1:0] MODE_GET   = 2'd2;
  localparam logic [1:0] MODE_SET   = 2'd3;

  // byte lanes of an argb word
  localparam int LANE_BLUE  = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_RED   = 2;
  localparam int LANE_ALPHA = 3;

  localparam logic [15:0] MULT_ONE = 16'h0100;
  localparam logic [7:0]  CHAN_MAX = 8'hFF;

  typedef struct packed {
    logic [3:0][15:0] mult;    // per lane, unsigned q8.8
    logic [3:0][8:0]  offset;  // per lane, two's complement
  } xform_cfg_t;

endpackage

FILE: hdl/bfct_xform.sv
module bfct_xform #(
  parameter int ADDR_W    = 12,
  parameter int HAS_ALPHA = bfct_pkg::HAS_ALPHA_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bfct_pkg::xform_cfg_t cfg,
  input  logic                in_valid,
  input  logic [ADDR_W-1:0]   in_addr,
  input  logic [31:0]         in_pixel,
  output logic                out_valid,
  output logic [ADDR_W-1:0]   out_addr,
  output logic [31:0]         out_pixel
);

  logic [3:0][23:0]    prod;
  logic [7:0]          alpha_raw;
  logic [ADDR_W-1:0]   addr_q;
  logic                valid_q;
  logic signed [17:0]  sum [4];
  logic [3:0][7:0]     chan;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid;
    end
  end

  // multiply stage, registered before the offset add
  always_ff @(posedge clk) begin
    if (in_valid) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= in_pixel[8*k +: 8] * cfg.mult[k];
      end
      alpha_raw <= in_pixel[31:24];
      addr_q    <= in_addr;
    end
  end

  // truncate, add signed offset, saturate to 0..255
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = $signed({2'b00, prod[k][23:8]}) +
               $signed({{9{cfg.offset[k][8]}}, cfg.offset[k]});
      if (sum[k][17]) begin
        chan[k] = '0;
      end else if (sum[k][16:8] != '0) begin
        chan[k] = bfct_pkg::CHAN_MAX;
      end else begin
        chan[k] = sum[k][7:0];
      end
    end
  end

  assign out_valid = valid_q;
  assign out_addr  = addr_q;
  assign out_pixel = {(HAS_ALPHA != 0) ? chan[bfct_pkg::LANE_ALPHA] : alpha_raw,
                      chan[bfct_pkg::LANE_RED],
                      chan[bfct_pkg::LANE_GREEN],
                      chan[bfct_pkg::LANE_BLUE]};

endmodule

FILE: hdl/bitmap_fill_and_color_transform.sv
// channel   direction  handshake              payload
// command   in         start & !busy          mode pos_x pos_y rect_width rect_height color_in
// result    out        done, one-cycle pulse  pixel_value
// config    in         apb psel/penable/pwrite 8 registers at 4*i
//
// fill and transform walk the rectangle one pixel per cycle over the pixel memory's
// write and registered read ports; busy drops with done, so the next transaction
// can go in while done is high and none overlaps another in memory.
// rst is synchronous and leaves the pixel memory alone; the receiver cannot stall done.
`include "bitmap_fill_and_color_transform_defines.svh"

module bitmap_fill_and_color_transform #(
  parameter int IMAGE_WIDTH  = bfct_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = bfct_pkg::IMAGE_HEIGHT_DEF,
  parameter int HAS_ALPHA    = bfct_pkg::HAS_ALPHA_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfct_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [5:0]                   pos_x,
  input  logic [5:0]                   pos_y,
  input  logic [6:0]                   rect_width,
  input  logic [6:0]                   rect_height,
  input  logic [31:0]                  color_in,
  output logic                         done,
  output logic [31:0]                  pixel_value
);

  localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = bfct_pkg::COORD_CMP_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // configuration
  bfct_pkg::xform_cfg_t cfg;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        cfg.mult[k]   <= bfct_pkg::MULT_ONE;
        cfg.offset[k] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        bfct_pkg::REG_MULT_RED:     cfg.mult[bfct_pkg::LANE_RED]     <= pwdata[15:0];
        bfct_pkg::REG_MULT_GREEN:   cfg.mult[bfct_pkg::LANE_GREEN]   <= pwdata[15:0];
        bfct_pkg::REG_MULT_BLUE:    cfg.mult[bfct_pkg::LANE_BLUE]    <= pwdata[15:0];
        bfct_pkg::REG_MULT_ALPHA:   cfg.mult[bfct_pkg::LANE_ALPHA]   <= pwdata[15:0];
        bfct_pkg::REG_OFFSET_RED:   cfg.offset[bfct_pkg::LANE_RED]   <= pwdata[8:0];
        bfct_pkg::REG_OFFSET_GREEN: cfg.offset[bfct_pkg::LANE_GREEN] <= pwdata[8:0];
        bfct_pkg::REG_OFFSET_BLUE:  cfg.offset[bfct_pkg::LANE_BLUE]  <= pwdata[8:0];
        bfct_pkg::REG_OFFSET_ALPHA: cfg.offset[bfct_pkg::LANE_ALPHA] <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      bfct_pkg::REG_MULT_RED:     prdata = {16'd0, cfg.mult[bfct_pkg::LANE_RED]};
      bfct_pkg::REG_MULT_GREEN:   prdata = {16'd0, cfg.mult[bfct_pkg::LANE_GREEN]};
      bfct_pkg::REG_MULT_BLUE:    prdata = {16'd0, cfg.mult[bfct_pkg::LANE_BLUE]};
      bfct_pkg::REG_MULT_ALPHA:   prdata = {16'd0, cfg.mult[bfct_pkg::LANE_ALPHA]};
      bfct_pkg::REG_OFFSET_RED:   prdata = {23'd0, cfg.offset[bfct_pkg::LANE_RED]};
      bfct_pkg::REG_OFFSET_GREEN: prdata = {23'd0, cfg.offset[bfct_pkg::LANE_GREEN]};
      bfct_pkg::REG_OFFSET_BLUE:  prdata = {23'd0, cfg.offset[bfct_pkg::LANE_BLUE]};
      bfct_pkg::REG_OFFSET_ALPHA: prdata = {23'd0, cfg.offset[bfct_pkg::LANE_ALPHA]};
      default:                    prdata = '0;
    endcase
  end

  // command sequencer
  logic [1:0]        state;
  logic [1:0]        cmd_mode;
  logic [5:0]        cmd_px;
  logic [5:0]        cmd_py;
  logic [6:0]        cmd_w;
  logic [6:0]        cmd_h;
  logic [31:0]       cmd_color;
  logic [6:0]        col;
  logic [6:0]        row;
  logic [ADDR_W-1:0] row_base;
  logic [31:0]       result;
  logic              accept;
  logic              single;

  logic [7:0]        cur_x;
  logic [7:0]        cur_y;
  logic              in_range;
  logic              issue;
  logic [ADDR_W-1:0] issue_addr;
  logic              fill_wr;
  logic              rd_en;

  // read pipeline
  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic [31:0]       mem_rdata;
  logic              xf_valid;
  logic [ADDR_W-1:0] xf_addr;
  logic [31:0]       xf_pixel;

  logic [31:0]       pixel_mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign single = (mode == bfct_pkg::MODE_GET) || (mode == bfct_pkg::MODE_SET);

  assign cur_x      = {2'b00, cmd_px} + {1'b0, col};
  assign cur_y      = {2'b00, cmd_py} + {1'b0, row};
  assign in_range   = ({{(CW-8){1'b0}}, cur_x} < CW'(IMAGE_WIDTH)) &&
                      ({{(CW-8){1'b0}}, cur_y} < CW'(IMAGE_HEIGHT));
  assign issue      = (state == ST_RUN) && in_range;
  // row base wraps modulo the address width, exact for every in-range row
  assign issue_addr = row_base + ADDR_W'(cur_x);
  assign fill_wr    = issue && ((cmd_mode == bfct_pkg::MODE_FILL) ||
                                (cmd_mode == bfct_pkg::MODE_SET));
  assign rd_en      = issue && ((cmd_mode == bfct_pkg::MODE_XFORM) ||
                                (cmd_mode == bfct_pkg::MODE_GET));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!single && ((rect_width == '0) || (rect_height == '0))) begin
              state <= ST_DRAIN;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if ((col == cmd_w - 7'd1) && (row == cmd_h - 7'd1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_valid && !xf_valid) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_mode  <= mode;
      cmd_px    <= pos_x;
      cmd_py    <= pos_y;
      cmd_w     <= single ? 7'd1 : rect_width;
      cmd_h     <= single ? 7'd1 : rect_height;
      cmd_color <= color_in;
      col       <= '0;
      row       <= '0;
      row_base  <= ADDR_W'(pos_y) * ADDR_W'(IMAGE_WIDTH);
      result    <= '0;
    end else if (state == ST_RUN) begin
      if (col == cmd_w - 7'd1) begin
        col      <= '0;
        row      <= row + 7'd1;
        row_base <= row_base + ADDR_W'(IMAGE_WIDTH);
      end else begin
        col <= col + 7'd1;
      end
    end
    if (s1_valid && (cmd_mode == bfct_pkg::MODE_GET)) begin
      result <= (HAS_ALPHA != 0) ? mem_rdata : {bfct_pkg::CHAN_MAX, mem_rdata[23:0]};
    end
    if ((state == ST_DRAIN) && !s1_valid && !xf_valid) begin
      pixel_value <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_addr <= issue_addr;
    end
  end

  // pixel memory, one write and one registered read port
  assign mem_we    = fill_wr || xf_valid;
  assign mem_waddr = xf_valid ? xf_addr : issue_addr;
  assign mem_wdata = xf_valid ? xf_pixel : cmd_color;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pixel_mem[mem_waddr][23:0] <= mem_wdata[23:0];
      // without an alpha plane, fill and set keep the stored alpha byte
      if ((HAS_ALPHA != 0) || xf_valid) begin
        pixel_mem[mem_waddr][31:24] <= mem_wdata[31:24];
      end
    end
    if (rd_en) begin
      mem_rdata <= pixel_mem[issue_addr];
    end
  end

  bfct_xform #(
    .ADDR_W    (ADDR_W),
    .HAS_ALPHA (HAS_ALPHA)
  ) u_xform (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s1_valid && (cmd_mode == bfct_pkg::MODE_XFORM)),
    .in_addr   (s1_addr),
    .in_pixel  (mem_rdata),
    .out_valid (xf_valid),
    .out_addr  (xf_addr),
    .out_pixel (xf_pixel)
  );

  `BFCT_ASSERT_NEXT(a_done_pulse, done, !done)
  `BFCT_ASSERT_SAME(a_done_idle, done, !busy)
  `BFCT_ASSERT_NEXT(a_accept_busy, accept, busy)
  `BFCT_ASSERT_SAME(a_no_wr_collide, xf_valid, !fill_wr)
  `BFCT_ASSERT_SAME(a_zero_unless_get, done && (cmd_mode != bfct_pkg::MODE_GET), pixel_value == '0)

endmodule
